// File: rtl/tcsw_pkg.sv
// tcsw_pkg: shared types and constants for the text console scroll window unit
// used by tcsw_ctrl, tcsw_datapath and text_console_scroll_window_unit
`default_nettype none

package tcsw_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned COLOR_W = 4;
   localparam int unsigned CELL_W = 16;
   localparam int unsigned OUT_COL_W = 7;
   localparam int unsigned OUT_ROW_W = 5;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR = 1'b1;

   localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'd14;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd1;
   localparam logic [CELL_W-1:0] BLANK_CELL = {BG_RESET, FG_RESET, CH_SPACE};

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic exec;
      logic read_capture;
      logic put;
      logic scroll_step;
      logic blank_step;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic is_bs;
      logic is_print;
      logic need_nl;
      logic nl_scroll;
      logic scroll_last;
      logic blank_last;
      logic scroll_none;
      logic blank_none;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/text_console_scroll_window_unit.sv
// text_console_scroll_window_unit: top level of the text console engine
// depends on tcsw_pkg, tcsw_ctrl and tcsw_datapath
`default_nettype none

// Text console with a COLS x ROWS cell memory (attribute high byte, character low byte)
// and a cursor held inside a scroll window. One item is worked on at a time. After
// reset a clearing pass writes every cell blank, one cell a cycle, and no item is
// taken until it is done; colour writes are taken throughout. A read passes through
// the EXEC, RDWAIT and RESULT states, a put through EXEC, PUT and RESULT, a backspace
// or a newline that does not scroll through EXEC and RESULT. A newline at the bottom row
// scrolls the window through the single write port of the cell memory at one cell a
// cycle, then writes the bottom row of the window blank; a character printed after the
// wrap is put last. A finished result sits in an output register, so the next item may
// be transferred before it is taken.

module text_console_scroll_window_unit #(
   parameter int COLS       = 80,
   parameter int ROWS       = 25,
   parameter int WIN_LEFT   = 1,
   parameter int WIN_RIGHT  = 78,
   parameter int WIN_TOP    = 1,
   parameter int WIN_BOTTOM = 22
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // char_code [7:0], read_col [14:8], read_row [19:15], zeros above
   input  wire logic [tcsw_pkg::REQ_DATA_W-1:0]          req_tdata,
   // opcode [0]
   input  wire logic                                     req_tuser,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // cursor_col [6:0], cursor_row [11:7], scrolled [12], cell_data [28:13], zeros above
   output logic [tcsw_pkg::RSP_DATA_W-1:0]               rsp_tdata,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic [tcsw_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [tcsw_pkg::COLOR_W-1:0]             csr_data
);

   tcsw_pkg::cmd_type    cmd;
   tcsw_pkg::status_type status;

   logic [tcsw_pkg::OUT_COL_W-1:0] rsp_cursor_col;
   logic [tcsw_pkg::OUT_ROW_W-1:0] rsp_cursor_row;
   logic                           rsp_scrolled;
   logic [tcsw_pkg::CELL_W-1:0]    rsp_cell_data;

   assign csr_ready = 1'b1;

   tcsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tcsw_datapath #(
      .COLS       (COLS),
      .ROWS       (ROWS),
      .WIN_LEFT   (WIN_LEFT),
      .WIN_RIGHT  (WIN_RIGHT),
      .WIN_TOP    (WIN_TOP),
      .WIN_BOTTOM (WIN_BOTTOM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .item_opcode    (req_tuser),
      .item_char_code (req_tdata[7:0]),
      .item_read_col  (req_tdata[14:8]),
      .item_read_row  (req_tdata[19:15]),
      .csr_write      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cell_data  (rsp_cell_data)
   );

   assign rsp_tdata = {3'b000, rsp_cell_data, rsp_scrolled, rsp_cursor_row, rsp_cursor_col};

endmodule

`default_nettype wire

// File: rtl/tcsw_ctrl.sv
// tcsw_ctrl: sequencing state machine for the console unit
// depends on tcsw_pkg; drives tcsw_datapath through command and status structs
`default_nettype none

module tcsw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tcsw_pkg::status_type status,
   output tcsw_pkg::cmd_type        cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_EXEC   = 9'b000000100,
      ST_RDWAIT = 9'b000001000,
      ST_PUT    = 9'b000010000,
      ST_SCROLL = 9'b000100000,
      ST_DRAIN  = 9'b001000000,
      ST_BLANK  = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type after_blank;

   always_comb begin
      after_blank = status.is_print ? ST_PUT : ST_RESULT;
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (status.is_read) begin
               state_in = ST_RDWAIT;
            end else if (status.is_bs) begin
               state_in = ST_RESULT;
            end else if (status.nl_scroll) begin
               priority if (!status.scroll_none) begin
                  state_in = ST_SCROLL;
               end else if (!status.blank_none) begin
                  state_in = ST_BLANK;
               end else begin
                  state_in = after_blank;
               end
            end else if (status.need_nl) begin
               state_in = after_blank;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_RDWAIT: begin
            cmd.read_capture = 1'b1;
            state_in = ST_RESULT;
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            state_in = ST_RESULT;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = status.blank_none ? after_blank : ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.blank_last) begin
               state_in = after_blank;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tcsw_datapath.sv
// tcsw_datapath: cell memory, cursor, scroll counters, colour registers and result register
// depends on tcsw_pkg; sequenced by tcsw_ctrl
`default_nettype none

module tcsw_datapath #(
   parameter int COLS       = 80,
   parameter int ROWS       = 25,
   parameter int WIN_LEFT   = 1,
   parameter int WIN_RIGHT  = 78,
   parameter int WIN_TOP    = 1,
   parameter int WIN_BOTTOM = 22
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tcsw_pkg::cmd_type                     cmd,
   output tcsw_pkg::status_type                       status,
   input  wire logic                                  item_opcode,
   input  wire logic [tcsw_pkg::CHAR_W-1:0]           item_char_code,
   input  wire logic [tcsw_pkg::OUT_COL_W-1:0]        item_read_col,
   input  wire logic [tcsw_pkg::OUT_ROW_W-1:0]        item_read_row,
   input  wire logic                                  csr_write,
   input  wire logic [tcsw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tcsw_pkg::COLOR_W-1:0]          csr_data,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic [tcsw_pkg::OUT_COL_W-1:0]             rsp_cursor_col,
   output logic [tcsw_pkg::OUT_ROW_W-1:0]             rsp_cursor_row,
   output logic                                       rsp_scrolled,
   output logic [tcsw_pkg::CELL_W-1:0]                rsp_cell_data
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int CMAX = ((WIN_LEFT > WIN_RIGHT) ? WIN_LEFT : WIN_RIGHT) + 1;
   localparam int CW = $clog2(CMAX + 1);
   localparam int RMAX = ((WIN_TOP > WIN_BOTTOM) ? WIN_TOP : WIN_BOTTOM) + 1;
   localparam int RW = $clog2(RMAX + 1);

   function automatic logic [AW-1:0] cell_addr(input logic [7:0] c, input logic [6:0] r);
      cell_addr = AW'(32'(r) * COLS + 32'(c));
   endfunction

   function automatic logic col_ok(input logic [8:0] c);
      col_ok = 32'(c) < COLS;
   endfunction

   function automatic logic row_ok(input logic [7:0] r);
      row_ok = 32'(r) < ROWS;
   endfunction

   logic [tcsw_pkg::CELL_W-1:0] mem [CELLS];
   logic [tcsw_pkg::CELL_W-1:0] mem_q_ff;

   logic                          op_ff;
   logic [tcsw_pkg::CHAR_W-1:0]   ch_ff;
   logic [tcsw_pkg::OUT_COL_W-1:0] rc_ff;
   logic [tcsw_pkg::OUT_ROW_W-1:0] rr_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] sc_col_ff, sc_col_in;
   logic [RW-1:0] sc_row_ff, sc_row_in;
   logic [RW-1:0] sc_src_row;
   logic [AW-1:0] clr_ff;

   logic          pend_ff;
   logic          pend_ok_ff;
   logic          pend_src_ok_ff;
   logic [AW-1:0] pend_addr_ff;

   logic [tcsw_pkg::COLOR_W-1:0] fg_ff;
   logic [tcsw_pkg::COLOR_W-1:0] bg_ff;
   logic [tcsw_pkg::CHAR_W-1:0]  attr;

   logic                         scrolled_ff;
   logic [tcsw_pkg::CELL_W-1:0]  rd_data_ff;
   logic                         rsp_valid_ff;
   logic [tcsw_pkg::OUT_COL_W-1:0] rsp_col_ff;
   logic [tcsw_pkg::OUT_ROW_W-1:0] rsp_row_ff;
   logic                         rsp_scrolled_ff;
   logic [tcsw_pkg::CELL_W-1:0]  rsp_cell_ff;

   logic is_read, is_bs, is_nl, is_print, need_nl, row_at_bottom;
   logic bs_left, bs_up;
   logic [CW-1:0] bs_col;
   logic [RW-1:0] bs_row;
   logic rd_ok;

   logic                        we;
   logic [AW-1:0]               waddr;
   logic [tcsw_pkg::CELL_W-1:0] wdata;
   logic                        re;
   logic [AW-1:0]               raddr;

   always_comb begin
      attr = {bg_ff, fg_ff};
      is_read = op_ff == tcsw_pkg::OP_READ;
      is_bs = !is_read && ch_ff == tcsw_pkg::CH_BS;
      is_nl = !is_read && ch_ff == tcsw_pkg::CH_NL;
      is_print = !is_read && !is_bs && !is_nl;
      need_nl = is_nl || (is_print && 32'(col_ff) >= WIN_RIGHT);
      row_at_bottom = 32'(row_ff) >= WIN_BOTTOM;
      bs_left = 32'(col_ff) > WIN_LEFT;
      bs_up = 32'(row_ff) > WIN_TOP;
      bs_col = bs_left ? col_ff - CW'(1) : CW'(WIN_RIGHT);
      bs_row = bs_left ? row_ff : row_ff - RW'(1);
      sc_src_row = sc_row_ff + RW'(1);
      rd_ok = col_ok(9'(rc_ff)) && row_ok(8'(rr_ff));

      status.clear_last = clr_ff == AW'(CELLS - 1);
      status.is_read = is_read;
      status.is_bs = is_bs;
      status.is_print = is_print;
      status.need_nl = need_nl;
      status.nl_scroll = need_nl && row_at_bottom;
      status.scroll_last = 32'(sc_col_ff) == WIN_RIGHT && 32'(sc_row_ff) == WIN_BOTTOM - 1;
      status.blank_last = 32'(sc_col_ff) == WIN_RIGHT;
      status.scroll_none = (WIN_TOP >= WIN_BOTTOM) || (WIN_LEFT > WIN_RIGHT);
      status.blank_none = WIN_LEFT > WIN_RIGHT;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // memory write port
   always_comb begin
      we = 1'b0;
      waddr = clr_ff;
      wdata = tcsw_pkg::BLANK_CELL;
      priority if (cmd.clear_step) begin
         we = 1'b1;
      end else if (pend_ff) begin
         we = pend_ok_ff;
         waddr = pend_addr_ff;
         wdata = pend_src_ok_ff ? mem_q_ff : '0;
      end else if (cmd.exec && is_bs) begin
         we = (bs_left || bs_up) && col_ok(9'(bs_col)) && row_ok(8'(bs_row));
         waddr = cell_addr(8'(bs_col), 7'(bs_row));
         wdata = {attr, tcsw_pkg::CH_SPACE};
      end else if (cmd.put) begin
         we = col_ok(9'(col_ff)) && row_ok(8'(row_ff));
         waddr = cell_addr(8'(col_ff), 7'(row_ff));
         wdata = {attr, ch_ff};
      end else if (cmd.blank_step) begin
         we = col_ok(9'(sc_col_ff)) && row_ok(8'(WIN_BOTTOM));
         waddr = cell_addr(8'(sc_col_ff), 7'(WIN_BOTTOM));
         wdata = {attr, tcsw_pkg::CH_SPACE};
      end else begin
         we = 1'b0;
      end
   end

   // memory read port
   always_comb begin
      re = 1'b0;
      raddr = cell_addr(8'(rc_ff), 7'(rr_ff));
      if (cmd.exec && is_read) begin
         re = rd_ok;
      end else if (cmd.scroll_step) begin
         re = 1'b1;
         raddr = cell_addr(8'(sc_col_ff), 7'(sc_src_row));
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         mem_q_ff <= mem[raddr];
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.exec) begin
         priority if (is_bs && (bs_left || bs_up)) begin
            col_in = bs_col;
            row_in = bs_row;
         end else if (need_nl) begin
            col_in = CW'(WIN_LEFT);
            row_in = row_at_bottom ? RW'(WIN_BOTTOM) : row_ff + RW'(1);
         end else begin
            col_in = col_ff;
         end
      end else if (cmd.put) begin
         col_in = col_ff + CW'(1);
      end
   end

   always_comb begin
      sc_col_in = sc_col_ff;
      sc_row_in = sc_row_ff;
      priority if (cmd.exec) begin
         sc_col_in = CW'(WIN_LEFT);
         sc_row_in = RW'(WIN_TOP);
      end else if (cmd.scroll_step) begin
         if (32'(sc_col_ff) == WIN_RIGHT) begin
            sc_col_in = CW'(WIN_LEFT);
            sc_row_in = sc_src_row;
         end else begin
            sc_col_in = sc_col_ff + CW'(1);
         end
      end else if (cmd.blank_step) begin
         sc_col_in = sc_col_ff + CW'(1);
      end else begin
         sc_col_in = sc_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= CW'(WIN_LEFT);
         row_ff <= RW'(WIN_TOP);
         clr_ff <= '0;
         pend_ff <= 1'b0;
         fg_ff <= tcsw_pkg::FG_RESET;
         bg_ff <= tcsw_pkg::BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         pend_ff <= cmd.scroll_step;
         if (csr_write) begin
            unique case (csr_index)
               tcsw_pkg::CSR_FG_COLOR: fg_ff <= csr_data;
               tcsw_pkg::CSR_BG_COLOR: bg_ff <= csr_data;
               default: fg_ff <= fg_ff;
            endcase
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sc_col_ff <= sc_col_in;
      sc_row_ff <= sc_row_in;
      pend_addr_ff <= cell_addr(8'(sc_col_ff), 7'(sc_row_ff));
      pend_ok_ff <= col_ok(9'(sc_col_ff)) && row_ok(8'(sc_row_ff));
      pend_src_ok_ff <= col_ok(9'(sc_col_ff)) && row_ok(8'(sc_src_row));
      if (cmd.load_item) begin
         op_ff <= item_opcode;
         ch_ff <= item_char_code;
         rc_ff <= item_read_col;
         rr_ff <= item_read_row;
         scrolled_ff <= 1'b0;
      end else if (cmd.exec && need_nl && row_at_bottom) begin
         scrolled_ff <= 1'b1;
      end
      if (cmd.read_capture) begin
         rd_data_ff <= rd_ok ? mem_q_ff : '0;
      end
      if (cmd.result_load) begin
         rsp_col_ff <= tcsw_pkg::OUT_COL_W'(col_ff);
         rsp_row_ff <= tcsw_pkg::OUT_ROW_W'(row_ff);
         rsp_scrolled_ff <= scrolled_ff;
         rsp_cell_ff <= is_read ? rd_data_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled = rsp_scrolled_ff;
   assign rsp_cell_data = rsp_cell_ff;

endmodule

`default_nettype wire
